// File: rtl/repeated_max_subarray_sum_macros.svh
// Assertion macros used by the port-level checker rmss_checker.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef REPEATED_MAX_SUBARRAY_SUM_MACROS_SVH
`define REPEATED_MAX_SUBARRAY_SUM_MACROS_SVH

// Same-cycle implication, reported by $error.
`define RMSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reported by $error.
`define RMSS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/rmss_pkg.sv
// Shared widths, modulus constants and the result type of the repeated
// maximum subarray sum block. No dependencies.
package rmss_pkg;

  localparam int ELEM_W = 15;
  localparam int RC_W   = 17;
  localparam int RES_W  = 30;

  localparam int MOD_K = 30;
  localparam logic [31:0] ANSWER_MOD    = 32'd1000000007;
  localparam logic [31:0] ANSWER_MOD_X2 = ANSWER_MOD << 1;

  localparam int MU_W = 31;
  localparam int BARRETT_SHIFT = MOD_K + 1;
  localparam logic [63:0] MU_FULL = (64'd1 << (2 * MOD_K)) / {32'd0, ANSWER_MOD};
  localparam logic [MU_W-1:0] BARRETT_MU = MU_FULL[MU_W-1:0];

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int FIFO_CW    = 5;

  typedef struct packed {
    logic [RES_W-1:0] max_sum_mod;
    logic             too_long;
  } rmss_result_t;

endpackage

// File: rtl/repeated_max_subarray_sum.sv
// Maximum subarray sum of a streamed array repeated repeat_count times, mod 1e9+7.
// Uses rmss_pkg for widths, the Barrett constants and the result type.
//
// One element is taken every cycle while in_stall is low. Running total, Kadane
// sums and prefix extremes update in the cycle an element is accepted; the element
// marked last also loads a snapshot into a six-stage result pipeline (snapshot,
// two-copy best, one multiply, one add and a Barrett reduction in two multiply
// stages, with the final correction on the way into the queue), so its result
// passes through the stages into the output queue, which then raises out_valid.
// The 16-entry output queue lets input continue while results wait; in_stall
// rises only while 16 results are outstanding (accepted last elements not yet
// taken at the output).
module repeated_max_subarray_sum
  import rmss_pkg::*;
#(
  parameter int MAX_LENGTH = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [ELEM_W-1:0] in_element_value,
  input  logic                     in_is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [RES_W-1:0]         out_max_sum_mod,
  output logic                     out_too_long,
  input  logic                     cfg_wr_en,
  input  logic [RC_W-1:0]          cfg_repeat_count
);

  localparam int CNT_W  = $clog2(MAX_LENGTH + 1);
  localparam int SUM_W  = $clog2(MAX_LENGTH) + 16;
  localparam int OPB_W  = SUM_W - 1;
  localparam int PROD_W = RC_W + OPB_W;
  localparam int X_W    = PROD_W + 1;
  localparam int Q_W    = X_W - (MOD_K - 1);
  localparam int QF_W   = Q_W + MU_W;
  localparam int QM_W   = Q_W + MOD_K;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LENGTH);

  logic [RC_W-1:0] rc_r;

  logic                    accept;
  logic                    full;
  logic signed [SUM_W-1:0] v_ext;
  logic signed [SUM_W-1:0] tot_sum, cur_sum, cur_clip;
  logic signed [SUM_W-1:0] tot_upd, cur_upd, best_upd, min_upd, max_upd;
  logic [CNT_W-1:0]        cnt_upd;
  logic                    ovf_upd;

  logic signed [SUM_W-1:0] tot_r, cur_r, best_r, min_r, max_r;
  logic signed [SUM_W-1:0] tot_nxt, cur_nxt, best_nxt, min_nxt, max_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    ovf_r, ovf_nxt;

  logic                    s1_vld_r, s1_tl_r;
  logic signed [SUM_W-1:0] s1_tot_r, s1_best_r, s1_min_r, s1_max_r;

  logic signed [SUM_W:0]   span, best_w, two_copy;
  logic                    tot_pos;
  logic [SUM_W-1:0]        base;
  logic [RC_W-1:0]         opa;

  logic                    s2_vld_r, s2_tl_r;
  logic [SUM_W-1:0]        s2_base_r;
  logic [RC_W-1:0]         s2_opa_r;
  logic [OPB_W-1:0]        s2_opb_r;

  logic                    s3_vld_r, s3_tl_r;
  logic [SUM_W-1:0]        s3_base_r;
  logic [PROD_W-1:0]       s3_prod_r;

  logic                    s4_vld_r, s4_tl_r;
  logic [X_W-1:0]          s4_x_r;

  logic [QF_W-1:0]         q_full;
  logic                    s5_vld_r, s5_tl_r;
  logic [Q_W-1:0]          s5_q_r;
  logic [31:0]             s5_xl_r;

  logic [QM_W-1:0]         qm;
  logic                    s6_vld_r, s6_tl_r;
  logic [31:0]             s6_r_r;

  logic [31:0]             r_red;
  rmss_result_t            push_data;
  logic                    push, pop;

  rmss_result_t            fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]      wr_ptr_r, rd_ptr_r;
  logic [FIFO_CW-1:0]      occ_r, occ_nxt, pend_r, pend_nxt;
  logic                    in_stall_r, in_stall_nxt;

  assign accept = in_valid && !in_stall_r;
  assign full   = cnt_r >= MAX_CNT;
  assign v_ext  = {{(SUM_W - ELEM_W){in_element_value[ELEM_W-1]}}, in_element_value};

  always_comb begin
    tot_sum  = tot_r + v_ext;
    cur_sum  = cur_r + v_ext;
    cur_clip = cur_sum[SUM_W-1] ? '0 : cur_sum;
    if (full) begin
      tot_upd  = tot_r;
      cur_upd  = cur_r;
      best_upd = best_r;
      min_upd  = min_r;
      max_upd  = max_r;
      cnt_upd  = cnt_r;
    end else begin
      tot_upd  = tot_sum;
      cur_upd  = cur_clip;
      best_upd = (cur_clip > best_r) ? cur_clip : best_r;
      min_upd  = (tot_sum < min_r) ? tot_sum : min_r;
      max_upd  = (tot_sum > max_r) ? tot_sum : max_r;
      cnt_upd  = cnt_r + 1'b1;
    end
    ovf_upd = ovf_r | full;

    if (in_is_last) begin
      tot_nxt  = '0;
      cur_nxt  = '0;
      best_nxt = '0;
      min_nxt  = '0;
      max_nxt  = '0;
      cnt_nxt  = '0;
      ovf_nxt  = 1'b0;
    end else begin
      tot_nxt  = tot_upd;
      cur_nxt  = cur_upd;
      best_nxt = best_upd;
      min_nxt  = min_upd;
      max_nxt  = max_upd;
      cnt_nxt  = cnt_upd;
      ovf_nxt  = ovf_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r   <= RC_W'(1);
      tot_r  <= '0;
      cur_r  <= '0;
      best_r <= '0;
      min_r  <= '0;
      max_r  <= '0;
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rc_r <= cfg_repeat_count;
      end
      if (accept) begin
        tot_r  <= tot_nxt;
        cur_r  <= cur_nxt;
        best_r <= best_nxt;
        min_r  <= min_nxt;
        max_r  <= max_nxt;
        cnt_r  <= cnt_nxt;
        ovf_r  <= ovf_nxt;
      end
    end
  end

  // two-copy best, multiplier operands
  always_comb begin
    span     = {s1_tot_r[SUM_W-1], s1_tot_r} - {s1_min_r[SUM_W-1], s1_min_r}
               + {s1_max_r[SUM_W-1], s1_max_r};
    best_w   = {s1_best_r[SUM_W-1], s1_best_r};
    two_copy = (best_w > span) ? best_w : span;
    base     = (rc_r <= RC_W'(1)) ? s1_best_r[SUM_W-1:0] : two_copy[SUM_W-1:0];
    tot_pos  = !s1_tot_r[SUM_W-1] && (s1_tot_r != '0);
    opa      = (rc_r >= RC_W'(2) && tot_pos) ? rc_r - RC_W'(2) : '0;
  end

  // Barrett quotient and final correction
  assign q_full = QF_W'(s4_x_r[X_W-1:MOD_K-1]) * QF_W'(BARRETT_MU);
  assign qm     = QM_W'(s5_q_r) * QM_W'(ANSWER_MOD[MOD_K-1:0]);

  always_comb begin
    if (s6_r_r >= ANSWER_MOD_X2) begin
      r_red = s6_r_r - ANSWER_MOD_X2;
    end else if (s6_r_r >= ANSWER_MOD) begin
      r_red = s6_r_r - ANSWER_MOD;
    end else begin
      r_red = s6_r_r;
    end
    push_data.max_sum_mod = r_red[RES_W-1:0];
    push_data.too_long    = s6_tl_r;
  end

  always_ff @(posedge clk) begin
    s1_tot_r  <= tot_upd;
    s1_best_r <= best_upd;
    s1_min_r  <= min_upd;
    s1_max_r  <= max_upd;
    s1_tl_r   <= ovf_upd;

    s2_base_r <= base;
    s2_opa_r  <= opa;
    s2_opb_r  <= s1_tot_r[OPB_W-1:0];
    s2_tl_r   <= s1_tl_r;

    s3_prod_r <= PROD_W'(s2_opa_r) * PROD_W'(s2_opb_r);
    s3_base_r <= s2_base_r;
    s3_tl_r   <= s2_tl_r;

    s4_x_r    <= X_W'(s3_prod_r) + X_W'(s3_base_r);
    s4_tl_r   <= s3_tl_r;

    s5_q_r    <= q_full[BARRETT_SHIFT +: Q_W];
    s5_xl_r   <= s4_x_r[31:0];
    s5_tl_r   <= s4_tl_r;

    s6_r_r    <= s5_xl_r - qm[31:0];
    s6_tl_r   <= s5_tl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      s6_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= accept && in_is_last;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      s6_vld_r <= s5_vld_r;
    end
  end

  // output queue and request credit
  assign push = s6_vld_r;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    occ_nxt      = occ_r + FIFO_CW'(push) - FIFO_CW'(pop);
    pend_nxt     = pend_r + FIFO_CW'(accept && in_is_last) - FIFO_CW'(pop);
    in_stall_nxt = pend_nxt >= FIFO_CW'(FIFO_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      occ_r      <= '0;
      pend_r     <= '0;
      in_stall_r <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      occ_r      <= occ_nxt;
      pend_r     <= pend_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall        = in_stall_r;
  assign out_valid       = occ_r != '0;
  assign out_max_sum_mod = fifo_r[rd_ptr_r].max_sum_mod;
  assign out_too_long    = fifo_r[rd_ptr_r].too_long;

endmodule

// File: rtl/rmss_checker.sv
// Port-level checker for repeated_max_subarray_sum, bound to the top level.
// Uses rmss_pkg and the assertion macros in repeated_max_subarray_sum_macros.svh.
`include "repeated_max_subarray_sum_macros.svh"

module rmss_checker
  import rmss_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_is_last,
  input logic             out_valid,
  input logic             out_stall,
  input logic [RES_W-1:0] out_max_sum_mod,
  input logic             out_too_long
);

  logic [FIFO_CW-1:0] pend_r, pend_nxt;

  assign pend_nxt = pend_r + FIFO_CW'(in_valid && !in_stall && in_is_last)
                    - FIFO_CW'(out_valid && !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  `RMSS_ASSERT_IMPLY(a_result_below_modulus, clk, rst_n, out_valid, out_max_sum_mod < ANSWER_MOD, "result not reduced below modulus")
  `RMSS_ASSERT_NEXT(a_stalled_result_holds, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_max_sum_mod) && $stable(out_too_long), "stalled result changed")
  `RMSS_ASSERT_IMPLY(a_no_spurious_result, clk, rst_n, out_valid, pend_r != '0, "result without a pending last element")
  `RMSS_ASSERT_IMPLY(a_credit_bound, clk, rst_n, !in_stall, pend_r < FIFO_CW'(FIFO_DEPTH), "input open with output queue full")

endmodule

bind repeated_max_subarray_sum rmss_checker u_rmss_checker (.*);

// File: tb/repeated_max_subarray_sum_tb.sv
// Testbench for repeated_max_subarray_sum: streams elements through a directed
// table and random arrays; checks results against a predictor or table values.
// Depends on rmss_pkg and the repeated_max_subarray_sum RTL.
module repeated_max_subarray_sum_tb;
  import rmss_pkg::*;

  localparam int ARRAY_LIMIT = 65536;
  localparam int PIPE_DRAIN = 12;
  localparam int QUIET_LIMIT = 5000;
  localparam longint MODULUS = longint'(ANSWER_MOD);
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 15'sh3FFF;
  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 15'sh4000;
  localparam logic [RC_W-1:0] RC_MAX = '1;

  typedef struct {
    bit                        set_rc;
    logic [RC_W-1:0]           rc;
    logic signed [ELEM_W-1:0]  value;
    bit                        last;
    bit                        typed;
    rmss_result_t              res;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] in_element_value = '0;
  logic                     in_is_last = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [RES_W-1:0]         out_max_sum_mod;
  logic                     out_too_long;
  logic                     cfg_wr_en = 1'b0;
  logic [RC_W-1:0]          cfg_repeat_count = '0;

  rmss_result_t pending_sums[$];
  rmss_result_t sum_head;
  dir_row_t     directed_rows[$];

  logic [RC_W-1:0] repeat_reg = 1;
  longint arr_total, run_sum, best_run, low_prefix, high_prefix;
  int     arr_len;
  bit     arr_overflow;

  int err_count = 0;
  int burst_left = 0;
  int quiet_cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;

  repeated_max_subarray_sum #(
    .MAX_LENGTH(ARRAY_LIMIT)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_element_value (in_element_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_max_sum_mod  (out_max_sum_mod),
    .out_too_long     (out_too_long),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_repeat_count (cfg_repeat_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic bit fold_element(input logic signed [ELEM_W-1:0] value, input bit last,
                                      output rmss_result_t res);
    longint v;
    longint two_copy;
    longint answer;
    v = longint'(value);
    res = '0;
    if (arr_len >= ARRAY_LIMIT) begin
      arr_overflow = 1'b1;
    end else begin
      arr_len++;
      arr_total += v;
      run_sum += v;
      if (run_sum < 0) run_sum = 0;
      if (run_sum > best_run) best_run = run_sum;
      if (arr_total < low_prefix) low_prefix = arr_total;
      if (arr_total > high_prefix) high_prefix = arr_total;
    end
    if (!last) return 1'b0;
    if (repeat_reg <= 1) begin
      answer = best_run % MODULUS;
    end else begin
      two_copy = arr_total - low_prefix + high_prefix;
      if (best_run > two_copy) two_copy = best_run;
      answer = two_copy % MODULUS;
      if (arr_total > 0) begin
        answer = (answer + ((longint'(repeat_reg) - 2) * arr_total) % MODULUS) % MODULUS;
      end
    end
    res.max_sum_mod = answer[RES_W-1:0];
    res.too_long = arr_overflow;
    arr_total = 0;
    run_sum = 0;
    best_run = 0;
    low_prefix = 0;
    high_prefix = 0;
    arr_len = 0;
    arr_overflow = 1'b0;
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(bit set_rc, logic [RC_W-1:0] rc, int value, bit last,
                                      bit typed, int exp_sum);
    dir_row_t row;
    row.set_rc = set_rc;
    row.rc = rc;
    row.value = value[ELEM_W-1:0];
    row.last = last;
    row.typed = typed;
    row.res.max_sum_mod = exp_sum[RES_W-1:0];
    row.res.too_long = 1'b0;
    return row;
  endfunction

  function automatic logic signed [ELEM_W-1:0] pick_value(int flavor);
    int v;
    if ($urandom_range(0, 15) == 0) return $urandom_range(0, 1) ? ELEM_MAX : ELEM_MIN;
    case (flavor)
      0: v = $urandom;
      1: v = ($urandom_range(0, 4) == 0) ? -$urandom_range(0, 10000) : $urandom_range(0, 10000);
      2: v = $urandom_range(0, 16) - 8;
      default: v = $urandom_range(0, 20000) - 10000;
    endcase
    return v[ELEM_W-1:0];
  endfunction

  task automatic send_element(input logic signed [ELEM_W-1:0] value, input bit last,
                              input bit typed, input rmss_result_t typed_res);
    rmss_result_t res;
    @(negedge clk);
    in_valid <= 1'b1;
    in_element_value <= value;
    in_is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (fold_element(value, last, res)) pending_sums.push_back(typed ? typed_res : res);
  endtask

  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(1, 8);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(0, 12);
    end
  endtask

  task automatic drain(int extra_cycles);
    @(negedge clk) in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (extra_cycles) @(posedge clk);
  endtask

  task automatic load_repeat_count(logic [RC_W-1:0] rc);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_repeat_count <= rc;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    repeat_reg = rc;
  endtask

  task automatic send_array(int span);
    int flavor;
    flavor = $urandom_range(0, 3);
    for (int i = 1; i <= span; i++) begin
      send_element(pick_value(flavor), i == span, 1'b0, '0);
      pace();
    end
  endtask

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 150);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 7) < 3;
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("unexpected result: max_sum_mod %0d too_long %0d", out_max_sum_mod, out_too_long);
        err_count++;
      end else begin
        sum_head = pending_sums.pop_front();
        if (out_max_sum_mod !== sum_head.max_sum_mod) begin
          $error("max_sum_mod: expected %0d, actual %0d", sum_head.max_sum_mod, out_max_sum_mod);
          err_count++;
        end
        if (out_too_long !== sum_head.too_long) begin
          $error("too_long: expected %0d, actual %0d", sum_head.too_long, out_too_long);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin : stimulus
    int phase_items;
    int span;
    logic [RC_W-1:0] rc_pick;

    directed_rows.push_back(mk_row(0, 0, 0, 1, 1, 0));
    directed_rows.push_back(mk_row(0, 0, -16384, 1, 1, 0));
    directed_rows.push_back(mk_row(0, 0, 16383, 1, 1, 16383));
    directed_rows.push_back(mk_row(0, 0, 10000, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, -10000, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 10000, 1, 0, 0));
    directed_rows.push_back(mk_row(1, 0, 5, 1, 1, 5));
    directed_rows.push_back(mk_row(1, 2, -3, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 4, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, -1, 1, 0, 0));
    directed_rows.push_back(mk_row(1, RC_MAX, 16383, 1, 0, 0));
    directed_rows.push_back(mk_row(1, 100000, -16384, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, -1, 1, 1, 0));
    directed_rows.push_back(mk_row(1, 3, 1, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, -16384, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 16383, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 2, 1, 0, 0));
    directed_rows.push_back(mk_row(1, 1, 16383, 0, 0, 0));
    directed_rows.push_back(mk_row(0, 0, 16383, 1, 1, 32766));

    arr_total = 0;
    run_sum = 0;
    best_run = 0;
    low_prefix = 0;
    high_prefix = 0;
    arr_len = 0;
    arr_overflow = 1'b0;

    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_rc) begin
        drain(PIPE_DRAIN);
        load_repeat_count(directed_rows[r].rc);
      end
      send_element(directed_rows[r].value, directed_rows[r].last, directed_rows[r].typed,
                   directed_rows[r].res);
      pace();
    end

    for (int p = 0; p < 8; p++) begin
      drain(PIPE_DRAIN);
      case (p)
        0: rc_pick = 1;
        1: rc_pick = 0;
        2: rc_pick = 2;
        3: rc_pick = RC_MAX;
        4: rc_pick = 100000;
        5: rc_pick = RC_W'($urandom_range(3, 100000));
        6: rc_pick = RC_W'($urandom);
        default: rc_pick = RC_W'($urandom_range(2, 5));
      endcase
      load_repeat_count(rc_pick);
      phase_items = 0;
      while (phase_items < 45) begin
        case ($urandom_range(0, 19))
          0: span = $urandom_range(31, 80);
          1, 2, 3, 4, 5: span = $urandom_range(9, 30);
          default: span = $urandom_range(1, 8);
        endcase
        send_array(span);
        phase_items += span;
        if ($urandom_range(0, 7) == 0) drain(0);
      end
    end

    drain(2 * PIPE_DRAIN);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
